### rtl/rsp_pkg.sv
// Shared definitions for the Reed-Solomon parity encoder: field constants,
// GF(256) arithmetic and the control struct that runs the cell chain.
// No dependencies.
package rsp_pkg;

    localparam int DATA_W         = 8;
    localparam int CFG_W          = 6;
    localparam int MAX_PARITY_DEF = 32;
    localparam int RESET_PARITY   = 10;

    // low byte of the field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [DATA_W-1:0] GF_POLY_LO = 8'h1D;
    localparam logic [DATA_W-1:0] GF_ONE     = 8'h01;

    typedef struct packed {
        logic step;   // data word absorbed this cycle
        logic last;   // ... and it closes the message
        logic build;  // one generator build step
        logic clear;  // drop remainder and generator
        logic pop;    // parity word taken at the output
    } t_cell_ctrl;

    function automatic logic [DATA_W-1:0] gf_xtime(input logic [DATA_W-1:0] x);
        gf_xtime = {x[DATA_W-2:0], 1'b0} ^ (x[DATA_W-1] ? GF_POLY_LO : '0);
    endfunction

    function automatic logic [DATA_W-1:0] gf_mul(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < DATA_W; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = acc;
    endfunction

endpackage

### rtl/rsp_cell.sv
// One cell of the encoder chain: a remainder byte, a generator coefficient
// and an output shift byte, sharing one GF(256) multiplier.
// Depends on rsp_pkg.
module rsp_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rsp_pkg::t_cell_ctrl            i_ctrl,
    input  logic [rsp_pkg::DATA_W-1:0]     i_fb,
    input  logic [rsp_pkg::DATA_W-1:0]     i_root,
    input  logic [rsp_pkg::DATA_W-1:0]     i_g_prev,
    input  logic [rsp_pkg::DATA_W-1:0]     i_r_next,
    input  logic [rsp_pkg::DATA_W-1:0]     i_ob_next,
    output logic [rsp_pkg::DATA_W-1:0]     o_g,
    output logic [rsp_pkg::DATA_W-1:0]     o_r,
    output logic [rsp_pkg::DATA_W-1:0]     o_ob
);

    logic [rsp_pkg::DATA_W-1:0] r_r;
    logic [rsp_pkg::DATA_W-1:0] r_g;
    logic [rsp_pkg::DATA_W-1:0] r_ob;
    logic [rsp_pkg::DATA_W-1:0] n_r;
    logic [rsp_pkg::DATA_W-1:0] n_g;
    logic [rsp_pkg::DATA_W-1:0] n_ob;
    logic [rsp_pkg::DATA_W-1:0] w_prod;
    logic [rsp_pkg::DATA_W-1:0] w_upd;

    // build: g[k] ^= g[k-1]*root ; encode: r[k] = r[k+1] ^ fb*g[k]
    assign w_prod = rsp_pkg::gf_mul(i_ctrl.build ? i_root : i_fb,
                                    i_ctrl.build ? i_g_prev : r_g);
    assign w_upd  = i_r_next ^ w_prod;

    always_comb begin
        n_r  = r_r;
        n_g  = r_g;
        n_ob = r_ob;
        if (i_ctrl.clear) begin
            n_r = '0;
            n_g = '0;
        end else begin
            if (i_ctrl.step) begin
                n_r = i_ctrl.last ? '0 : w_upd;
            end
            if (i_ctrl.build) begin
                n_g = r_g ^ w_prod;
            end
        end
        if (i_ctrl.step && i_ctrl.last) begin
            n_ob = w_upd;
        end else if (i_ctrl.pop) begin
            n_ob = i_ob_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r <= '0;
            r_g <= '0;
        end else begin
            r_r <= n_r;
            r_g <= n_g;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob <= n_ob;
    end

    assign o_g  = r_g;
    assign o_r  = r_r;
    assign o_ob = r_ob;

endmodule

### rtl/reed_solomon_parity_encoder.sv
// Systematic Reed-Solomon parity encoder, GF(256) with polynomial 0x11D, generator
// prod (x + 2^i), i = 0..n-1, n = parity_count clamped to 1..MAX_PARITY (0 reads as 1).
// One data word is absorbed per cycle by a chain of MAX_PARITY cells. The word marked
// last loads the n remainder bytes into an output shift chain, highest degree first;
// the first parity word is valid the cycle after, and the chain drains one word per
// cycle while the receiver is ready, as the next message streams in. A last word is
// held off until the final parity word of the previous message is leaving, so a
// stalled receiver stalls it too. After reset and after every parity_count write the
// generator is rebuilt, during which no data word is accepted; a write also drops
// any message in progress. Depends on rsp_pkg and rsp_cell.
module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsp_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rsp_pkg::DATA_W-1:0]     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rsp_pkg::DATA_W-1:0]     o_parity_byte,
    output logic                           o_last_parity
);

    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam logic [CNT_W-1:0] RST_N_VAL =
        CNT_W'((rsp_pkg::RESET_PARITY > MAX_PARITY) ? MAX_PARITY : rsp_pkg::RESET_PARITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    function automatic logic [CNT_W-1:0] clamp_n(input logic [rsp_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            clamp_n = CNT_ONE;
        end else if (int'(v) > MAX_PARITY) begin
            clamp_n = CNT_W'(MAX_PARITY);
        end else begin
            clamp_n = CNT_W'(v);
        end
    endfunction

    logic [CNT_W-1:0]              r_n;
    logic [CNT_W-1:0]              r_bld_cnt;
    logic [CNT_W-1:0]              r_out_cnt;
    logic [rsp_pkg::DATA_W-1:0]    r_root;
    logic [CNT_W-1:0]              n_n;
    logic [CNT_W-1:0]              n_bld_cnt;
    logic [CNT_W-1:0]              n_out_cnt;
    logic [rsp_pkg::DATA_W-1:0]    n_root;

    logic                          w_building;
    logic                          w_out_free;
    logic                          w_in_acc;
    logic                          w_pop;
    logic [rsp_pkg::DATA_W-1:0]    w_fb;
    rsp_pkg::t_cell_ctrl           w_ctrl;

    logic [rsp_pkg::DATA_W-1:0]    w_r  [MAX_PARITY+1];
    logic [rsp_pkg::DATA_W-1:0]    w_ob [MAX_PARITY+1];
    logic [rsp_pkg::DATA_W-1:0]    w_g  [MAX_PARITY];

    assign w_building  = (r_bld_cnt != '0);
    // last parity word leaving frees the output chain in the same cycle
    assign w_out_free  = (r_out_cnt == '0) || ((r_out_cnt == CNT_ONE) && i_out_ready);
    assign o_in_ready  = !w_building && (!i_last_byte || w_out_free);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_out_cnt != '0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign w_fb        = i_data_byte ^ w_r[0];

    assign o_parity_byte = w_ob[0];
    assign o_last_parity = (r_out_cnt == CNT_ONE);

    always_comb begin
        w_ctrl.step  = w_in_acc;
        w_ctrl.last  = i_last_byte;
        w_ctrl.build = w_building && !i_cfg_we;
        w_ctrl.clear = i_cfg_we;
        w_ctrl.pop   = w_pop;
    end

    always_comb begin
        n_n       = r_n;
        n_bld_cnt = r_bld_cnt;
        n_root    = r_root;
        n_out_cnt = r_out_cnt;
        if (i_cfg_we) begin
            n_n       = clamp_n(i_cfg_data);
            n_bld_cnt = clamp_n(i_cfg_data);
            n_root    = rsp_pkg::GF_ONE;
        end else if (w_building) begin
            n_bld_cnt = r_bld_cnt - CNT_ONE;
            n_root    = rsp_pkg::gf_xtime(r_root);
        end
        if (w_in_acc && i_last_byte) begin
            n_out_cnt = r_n;
        end else if (w_pop) begin
            n_out_cnt = r_out_cnt - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= RST_N_VAL;
            r_bld_cnt <= RST_N_VAL;
            r_root    <= rsp_pkg::GF_ONE;
            r_out_cnt <= '0;
        end else begin
            r_n       <= n_n;
            r_bld_cnt <= n_bld_cnt;
            r_root    <= n_root;
            r_out_cnt <= n_out_cnt;
        end
    end

    // cells past n hold zero remainder and zero coefficient, so the chain
    // end is fed with zeros whatever n is
    assign w_r[MAX_PARITY]  = '0;
    assign w_ob[MAX_PARITY] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_PARITY; k++) begin : g_cell
            logic [rsp_pkg::DATA_W-1:0] w_g_prev;
            if (k == 0) begin : g_head
                assign w_g_prev = rsp_pkg::GF_ONE;
            end else begin : g_body
                assign w_g_prev = w_g[k-1];
            end
            rsp_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_fb      (w_fb),
                .i_root    (r_root),
                .i_g_prev  (w_g_prev),
                .i_r_next  (w_r[k+1]),
                .i_ob_next (w_ob[k+1]),
                .o_g       (w_g[k]),
                .o_r       (w_r[k]),
                .o_ob      (w_ob[k])
            );
        end
    endgenerate

`ifndef SYNTH
    a_out_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt <= r_n)
        else $error("parity count in flight exceeds parity length");

    a_no_accept_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_building |-> !o_in_ready)
        else $error("data word accepted during generator build");

    a_last_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_byte) |=> (o_out_valid && (r_out_cnt == $past(r_n))))
        else $error("last word did not load the parity chain");
`endif

endmodule
